@@ rtl/sss_pkg.sv @@
// ============================================================================
// sss_pkg
// Shared widths, operation codes and payload types of the sample stream
// statistics block.
// ============================================================================
package sss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 65536;

    localparam int COUNT_W = 17;
    localparam int SUM_W   = 33;
    localparam int SUMSQ_W = 47;

    // Datapath of the shared iterative unit.
    localparam int X_W    = 80;
    localparam int Y_W    = 64;
    localparam int Z_W    = 33;
    localparam int STEP_W = 7;

    localparam int DIV_STEPS  = 80;
    localparam int MUL_STEPS  = 33;
    localparam int SQRT_STEPS = 24;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_MSUB = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;
    localparam logic [1:0] OP_SQRT = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic [16:0]        sample_count;
        logic signed [23:0] mean_value;
        logic [39:0]        variance;
        logic [23:0]        std_dev;
        logic [23:0]        rms_value;
        logic               variance_valid;
        logic               overflow;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        logic signed [SUM_W-1:0]       sum;
        logic [SUMSQ_W-1:0]            sumsq;
        logic signed [SAMPLE_BITS-1:0] run_min;
        logic signed [SAMPLE_BITS-1:0] run_max;
        logic                          dropped;
    } acc_stat_t;

    typedef struct packed {
        logic           start;
        logic [1:0]     op;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [Z_W-1:0] z;
    } alu_req_t;

    typedef struct packed {
        logic           done;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [Z_W-1:0] z;
    } alu_rsp_t;

endpackage

@@ rtl/sample_stream_statistics.sv @@
// ============================================================================
// sample_stream_statistics
// Minimum, maximum, count, mean, sample variance, standard deviation and RMS
// of a profile of signed samples whose final sample carries a last mark.
// ============================================================================
//
//   Channel   Prefix  Carries                         Per transfer
//   input     s_      sample, last                    one profile sample
//   result    m_      statistics of one profile       one per marked sample
//
// Samples without the last mark are taken one per cycle while s_ready is high.
// After a marked sample, s_ready stays low while the shared unit runs three
// divisions at one quotient bit per cycle, three shift-add multiplies and two
// square roots at one result bit per cycle (two divisions and one square root
// when the profile holds one sample).
// Reset is synchronous and clears the accumulators and the sequencer.
// A result waiting on m_ready holds the next marked sample's result back, and
// s_ready stays low until that result is loaded.
module sample_stream_statistics (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sss_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sss_pkg::out_item_t  m_item
);

    sss_pkg::acc_stat_t stat;
    sss_pkg::alu_req_t  req;
    sss_pkg::alu_rsp_t  rsp;
    sss_pkg::out_item_t res_item;
    sss_pkg::out_item_t m_item_reg;

    logic idle;
    logic take;
    logic out_free;
    logic res_load;
    logic m_valid_reg;

    assign s_ready  = idle;
    assign take     = s_valid && idle;
    assign out_free = !m_valid_reg || m_ready;

    sss_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .clear   (res_load),
        .sample  (s_item.sample),
        .stat    (stat)
    );

    sss_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    sss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (take && s_item.last),
        .out_free (out_free),
        .stat     (stat),
        .rsp      (rsp),
        .req      (req),
        .idle     (idle),
        .res_load (res_load),
        .res_item (res_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ rtl/sss_alu.sv @@
// ============================================================================
// sss_alu
// Shared iterative unit: shift-add multiply, multiply-subtract, restoring
// division and restoring square root, all through one 64-bit adder.
// ============================================================================
module sss_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  sss_pkg::alu_req_t req,
    output sss_pkg::alu_rsp_t rsp
);

    localparam int XW = sss_pkg::X_W;
    localparam int YW = sss_pkg::Y_W;
    localparam int ZW = sss_pkg::Z_W;
    localparam int SW = sss_pkg::STEP_W;

    logic [1:0]    op_reg;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;
    logic [SW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [YW-1:0] rem_sh;
    logic [YW-1:0] opa, opb;
    logic          sub;
    logic [YW:0]   sum_full;
    logic          ge;
    logic [SW-1:0] steps;

    always_comb begin
        if (op_reg == sss_pkg::OP_SQRT) begin
            rem_sh = {y_reg[YW-3:0], x_reg[XW-1:XW-2]};
        end else begin
            rem_sh = {y_reg[YW-2:0], x_reg[XW-1]};
        end

        case (op_reg)
            sss_pkg::OP_MUL: begin
                opa = y_reg;
                opb = x_reg[YW-1:0];
                sub = 1'b0;
            end
            sss_pkg::OP_MSUB: begin
                opa = y_reg;
                opb = x_reg[YW-1:0];
                sub = 1'b1;
            end
            sss_pkg::OP_DIV: begin
                opa = rem_sh;
                opb = YW'(z_reg);
                sub = 1'b1;
            end
            default: begin
                opa = rem_sh;
                opb = YW'({z_reg, 2'b01});
                sub = 1'b1;
            end
        endcase

        // For a subtraction the carry out is set when opa >= opb.
        sum_full = {1'b0, opa} + {1'b0, opb ^ {YW{sub}}} + (YW + 1)'(sub);
        ge       = sum_full[YW];

        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        case (op_reg)
            sss_pkg::OP_MUL, sss_pkg::OP_MSUB: begin
                if (z_reg[0]) begin
                    y_next = sum_full[YW-1:0];
                end
                x_next = {x_reg[XW-2:0], 1'b0};
                z_next = {1'b0, z_reg[ZW-1:1]};
            end
            sss_pkg::OP_DIV: begin
                y_next = ge ? sum_full[YW-1:0] : rem_sh;
                x_next = {x_reg[XW-2:0], ge};
            end
            default: begin
                y_next = ge ? sum_full[YW-1:0] : rem_sh;
                z_next = {z_reg[ZW-2:0], ge};
                x_next = {x_reg[XW-3:0], 2'b00};
            end
        endcase

        case (req.op)
            sss_pkg::OP_MUL, sss_pkg::OP_MSUB: steps = SW'(sss_pkg::MUL_STEPS);
            sss_pkg::OP_DIV:                   steps = SW'(sss_pkg::DIV_STEPS);
            default:                           steps = SW'(sss_pkg::SQRT_STEPS);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == SW'(1));
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - SW'(1);
                if (cnt_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            op_reg <= req.op;
            x_reg  <= req.x;
            y_reg  <= req.y;
            z_reg  <= req.z;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = z_reg;

endmodule

@@ rtl/sss_accum.sv @@
// ============================================================================
// sss_accum
// Per-profile accumulators: count, sum, sum of squares, minimum, maximum
// and the dropped-sample flag.
// ============================================================================
module sss_accum (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  take,
    input  logic                                  clear,
    input  logic signed [sss_pkg::SAMPLE_BITS-1:0] sample,
    output sss_pkg::acc_stat_t                    stat
);

    localparam int BW  = sss_pkg::SAMPLE_BITS;
    localparam int CW  = sss_pkg::COUNT_W;
    localparam int SUW = sss_pkg::SUM_W;
    localparam int SQW = sss_pkg::SUMSQ_W;

    localparam logic signed [BW-1:0] MOST_POS = {1'b0, {(BW - 1){1'b1}}};
    localparam logic signed [BW-1:0] MOST_NEG = {1'b1, {(BW - 1){1'b0}}};

    logic [CW-1:0]          count_reg;
    logic signed [SUW-1:0]  sum_reg;
    logic [SQW-1:0]         sumsq_reg;
    logic signed [BW-1:0]   min_reg;
    logic signed [BW-1:0]   max_reg;
    logic                   dropped_reg;

    logic signed [2*BW-1:0] square;

    assign square = sample * sample;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            min_reg     <= MOST_POS;
            max_reg     <= MOST_NEG;
            dropped_reg <= 1'b0;
        end else if (take) begin
            if (count_reg < CW'(sss_pkg::MAX_SAMPLES)) begin
                count_reg <= count_reg + CW'(1);
                sum_reg   <= sum_reg + SUW'(sample);
                sumsq_reg <= sumsq_reg + SQW'($unsigned(square));
                if (sample < min_reg) begin
                    min_reg <= sample;
                end
                if (sample > max_reg) begin
                    max_reg <= sample;
                end
            end else begin
                dropped_reg <= 1'b1;
            end
        end
    end

    assign stat.count   = count_reg;
    assign stat.sum     = sum_reg;
    assign stat.sumsq   = sumsq_reg;
    assign stat.run_min = min_reg;
    assign stat.run_max = max_reg;
    assign stat.dropped = dropped_reg;

endmodule

@@ rtl/sss_ctrl.sv @@
// ============================================================================
// sss_ctrl
// Sequencer that runs the end-of-profile arithmetic on the shared unit and
// assembles the result.
// ============================================================================
module sss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    input  logic                out_free,
    input  sss_pkg::acc_stat_t  stat,
    input  sss_pkg::alu_rsp_t   rsp,
    output sss_pkg::alu_req_t   req,
    output logic                idle,
    output logic                res_load,
    output sss_pkg::out_item_t  res_item
);

    localparam int XW  = sss_pkg::X_W;
    localparam int YW  = sss_pkg::Y_W;
    localparam int ZW  = sss_pkg::Z_W;
    localparam int CW  = sss_pkg::COUNT_W;
    localparam int SUW = sss_pkg::SUM_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MEAN     = 4'd1;
    localparam logic [3:0] ST_RMS_DIV  = 4'd2;
    localparam logic [3:0] ST_RMS_SQRT = 4'd3;
    localparam logic [3:0] ST_SQ_MUL   = 4'd4;
    localparam logic [3:0] ST_SUM_MSUB = 4'd5;
    localparam logic [3:0] ST_DEN_MUL  = 4'd6;
    localparam logic [3:0] ST_VAR_DIV  = 4'd7;
    localparam logic [3:0] ST_SD_SQRT  = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0]    state_reg;
    logic          run_reg;
    logic [YW-1:0] p_reg;
    logic [ZW-1:0] den_reg;
    logic [23:0]   mean_reg;
    logic [39:0]   var_reg;
    logic [23:0]   sd_reg;
    logic [23:0]   rms_reg;

    logic           n_ge2;
    logic           sum_neg;
    logic [SUW-1:0] sum_abs;
    logic [23:0]    mean_mag;
    logic           working;

    assign n_ge2   = |stat.count[CW-1:1];
    assign sum_neg = stat.sum[SUW-1];
    assign sum_abs = sum_neg ? $unsigned(-stat.sum) : $unsigned(stat.sum);

    // Floor toward minus infinity: a negative sum with a remainder rounds
    // one further away from zero.
    assign mean_mag = rsp.x[23:0] + 24'(sum_neg && (|rsp.y[ZW-1:0]));

    assign working = (state_reg != ST_IDLE) && (state_reg != ST_DONE);

    always_comb begin
        req.start = working && !run_reg;
        req.op    = sss_pkg::OP_DIV;
        req.x     = '0;
        req.y     = '0;
        req.z     = ZW'(stat.count);
        case (state_reg)
            ST_MEAN: begin
                req.x = XW'({sum_abs[SUW-2:0], 8'b0});
            end
            ST_RMS_DIV: begin
                req.x = XW'({stat.sumsq, 16'b0});
            end
            ST_RMS_SQRT, ST_SD_SQRT: begin
                req.op = sss_pkg::OP_SQRT;
                req.x  = {p_reg[47:0], 32'b0};
                req.z  = '0;
            end
            ST_SQ_MUL: begin
                req.op = sss_pkg::OP_MUL;
                req.x  = XW'(stat.sumsq);
            end
            ST_SUM_MSUB: begin
                req.op = sss_pkg::OP_MSUB;
                req.x  = XW'(sum_abs[SUW-2:0]);
                req.y  = p_reg;
                req.z  = ZW'(sum_abs[SUW-2:0]);
            end
            ST_DEN_MUL: begin
                req.op = sss_pkg::OP_MUL;
                req.x  = XW'(stat.count);
                req.z  = ZW'(stat.count - CW'(1));
            end
            ST_VAR_DIV: begin
                req.x = {p_reg, 16'b0};
                req.z = den_reg;
            end
            default: begin
                req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            run_reg   <= 1'b0;
        end else begin
            if (req.start) begin
                run_reg <= 1'b1;
            end
            if (rsp.done) begin
                run_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (go) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (rsp.done) begin
                        mean_reg  <= sum_neg ? -mean_mag : mean_mag;
                        state_reg <= ST_RMS_DIV;
                    end
                end
                ST_RMS_DIV: begin
                    if (rsp.done) begin
                        p_reg     <= rsp.x[YW-1:0];
                        state_reg <= ST_RMS_SQRT;
                    end
                end
                ST_RMS_SQRT: begin
                    if (rsp.done) begin
                        rms_reg <= rsp.z[23:0];
                        if (n_ge2) begin
                            state_reg <= ST_SQ_MUL;
                        end else begin
                            var_reg   <= '0;
                            sd_reg    <= '0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SQ_MUL: begin
                    if (rsp.done) begin
                        p_reg     <= rsp.y;
                        state_reg <= ST_SUM_MSUB;
                    end
                end
                ST_SUM_MSUB: begin
                    if (rsp.done) begin
                        p_reg     <= rsp.y;
                        state_reg <= ST_DEN_MUL;
                    end
                end
                ST_DEN_MUL: begin
                    if (rsp.done) begin
                        den_reg   <= rsp.y[ZW-1:0];
                        state_reg <= ST_VAR_DIV;
                    end
                end
                ST_VAR_DIV: begin
                    if (rsp.done) begin
                        p_reg     <= rsp.x[YW-1:0];
                        var_reg   <= rsp.x[47:8];
                        state_reg <= ST_SD_SQRT;
                    end
                end
                ST_SD_SQRT: begin
                    if (rsp.done) begin
                        sd_reg    <= rsp.z[23:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle     = (state_reg == ST_IDLE);
    assign res_load = (state_reg == ST_DONE) && out_free;

    assign res_item.min_value      = stat.run_min;
    assign res_item.max_value      = stat.run_max;
    assign res_item.sample_count   = stat.count;
    assign res_item.mean_value     = mean_reg;
    assign res_item.variance       = var_reg;
    assign res_item.std_dev        = sd_reg;
    assign res_item.rms_value      = rms_reg;
    assign res_item.variance_valid = n_ge2;
    assign res_item.overflow       = stat.dropped;

endmodule

@@ rtl/sss_checker.sv @@
// ============================================================================
// sss_checker
// Port-level checks of the sample stream statistics block, bound to the top
// level.
// ============================================================================
module sss_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input sss_pkg::in_item_t  s_item,
    input logic               m_valid,
    input logic               m_ready,
    input sss_pkg::out_item_t m_item
);

    // A stalled result must hold.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // The end-of-profile arithmetic blocks input right after a marked sample.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.last |=> !s_ready)
        else $error("input taken during end-of-profile arithmetic");

    // The variance is flagged valid exactly when two or more samples were kept,
    // and is zero otherwise.
    a_var_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.variance_valid == (m_item.sample_count >= 17'd2)) &&
                    (m_item.variance_valid ||
                     (m_item.variance == 40'd0 && m_item.std_dev == 24'd0)))
        else $error("variance flag inconsistent with sample count");

    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_item.min_value) <= $signed(m_item.max_value)) &&
                    (m_item.sample_count != 17'd0))
        else $error("result minimum above maximum or empty profile");

endmodule

bind sample_stream_statistics sss_checker u_sss_checker (.*);
